/* hw/rtl/frop_pkg.sv */
// Package for the float reduction operator ALU: operation codes, constants
// and the stage-to-stage record types. No dependencies.
package frop_pkg;

    typedef enum logic [3:0] {
        OP_MAX  = 4'd0,
        OP_MIN  = 4'd1,
        OP_SUM  = 4'd2,
        OP_PROD = 4'd3,
        OP_LAND = 4'd4,
        OP_BAND = 4'd5,
        OP_LOR  = 4'd6,
        OP_BOR  = 4'd7,
        OP_LXOR = 4'd8
    } op_t;

    localparam logic [31:0] ONE_BITS    = 32'h3F80_0000;
    localparam logic [31:0] DEFAULT_NAN = 32'h7FC0_0000;

    // Result kinds carried from the front stage to the back.
    typedef enum logic [2:0] {
        K_DIRECT = 3'd0,
        K_SUM    = 3'd1,
        K_PROD   = 3'd2,
        K_INT    = 3'd3,
        K_NANQ   = 3'd4
    } kind_t;

    // Stage 1 record: operands decoded.
    typedef struct packed {
        logic        last;
        kind_t       kind;
        logic [31:0] direct;
        logic        sa;
        logic        sb;
        logic [9:0]  ea;
        logic [9:0]  eb;
        logic [23:0] ma;
        logic [23:0] mb;
        logic [31:0] ival;
    } s1_t;

    // Stage 2 record: unrounded result sign, exponent and 27+ bit mantissa.
    typedef struct packed {
        logic        last;
        kind_t       kind;
        logic [31:0] direct;
        logic        sign;
        logic signed [11:0] exp;
        logic [49:0] mant;
        logic        zero;
    } s2_t;

    // Stage 3 record: normalised, ready to round.
    typedef struct packed {
        logic        last;
        kind_t       kind;
        logic [31:0] direct;
        logic        sign;
        logic signed [11:0] exp;
        logic [26:0] mant;
        logic        zero;
    } s3_t;

endpackage

/* hw/rtl/frop_decode.sv */
// Front stage of the float reduction operator ALU: compares, logical tests,
// integer truncation and special-case detection. Depends on frop_pkg.
module frop_decode (
    input  logic        aclk,
    input  logic        en,
    input  logic [3:0]  operation,
    input  logic [31:0] a,
    input  logic [31:0] b,
    input  logic        last,
    output frop_pkg::s1_t q_reg
);
    frop_pkg::s1_t q_next;

    function automatic logic is_nan(input logic [31:0] x);
        is_nan = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
    endfunction

    function automatic logic is_inf(input logic [31:0] x);
        is_inf = (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
    endfunction

    function automatic logic is_zero(input logic [31:0] x);
        is_zero = (x[30:0] == 31'd0);
    endfunction

    function automatic logic [31:0] trunc_i32(input logic [31:0] x);
        logic [7:0]  e;
        logic [54:0] m;
        logic [31:0] mag;
        e = x[30:23];
        m = {31'd0, 1'b1, x[22:0]};
        mag = 32'd0;
        if (is_nan(x) || e < 8'd127) begin
            trunc_i32 = 32'd0;
        end else if (e >= 8'd158) begin
            trunc_i32 = x[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            m = m << (e - 8'd127);
            mag = m[54:23];
            trunc_i32 = x[31] ? (~mag + 32'd1) : mag;
        end
    endfunction

    // Total order of non-NaN floats as sign-magnitude keys.
    function automatic logic less(input logic [31:0] x, input logic [31:0] y);
        if (is_nan(x) || is_nan(y) || (is_zero(x) && is_zero(y))) begin
            less = 1'b0;
        end else if (x[31] != y[31]) begin
            less = x[31];
        end else if (x[31]) begin
            less = x[30:0] > y[30:0];
        end else begin
            less = x[30:0] < y[30:0];
        end
    endfunction

    always_comb begin
        logic nza, nzb, nan_a, nan_b;
        nza = !is_zero(a);
        nzb = !is_zero(b);
        nan_a = is_nan(a);
        nan_b = is_nan(b);
        q_next = '0;
        q_next.last = last;
        q_next.kind = frop_pkg::K_DIRECT;
        q_next.sa = a[31];
        q_next.sb = b[31];
        q_next.ea = (a[30:23] == 8'd0) ? 10'd1 : {2'b00, a[30:23]};
        q_next.eb = (b[30:23] == 8'd0) ? 10'd1 : {2'b00, b[30:23]};
        q_next.ma = {a[30:23] != 8'd0, a[22:0]};
        q_next.mb = {b[30:23] != 8'd0, b[22:0]};
        unique case (operation) inside
            frop_pkg::OP_MAX: q_next.direct = less(b, a) ? a : b;
            frop_pkg::OP_MIN: q_next.direct = less(a, b) ? a : b;
            frop_pkg::OP_LAND: q_next.direct = (nza && nzb) ? frop_pkg::ONE_BITS : 32'd0;
            frop_pkg::OP_LOR: q_next.direct = (nza || nzb) ? frop_pkg::ONE_BITS : 32'd0;
            frop_pkg::OP_LXOR: q_next.direct = (nza != nzb) ? frop_pkg::ONE_BITS : 32'd0;
            frop_pkg::OP_BAND, frop_pkg::OP_BOR: begin
                q_next.kind = frop_pkg::K_INT;
                q_next.ival = (operation == frop_pkg::OP_BAND) ?
                              (trunc_i32(a) & trunc_i32(b)) : (trunc_i32(a) | trunc_i32(b));
            end
            frop_pkg::OP_SUM, frop_pkg::OP_PROD: begin
                q_next.kind = (operation == frop_pkg::OP_SUM) ? frop_pkg::K_SUM
                                                               : frop_pkg::K_PROD;
                if (nan_a) begin
                    q_next.kind = frop_pkg::K_NANQ;
                    q_next.direct = a | 32'h0040_0000;
                end else if (nan_b) begin
                    q_next.kind = frop_pkg::K_NANQ;
                    q_next.direct = b | 32'h0040_0000;
                end else if (operation == frop_pkg::OP_SUM) begin
                    if (is_inf(a) && is_inf(b) && (a[31] != b[31])) begin
                        q_next.kind = frop_pkg::K_NANQ;
                        q_next.direct = frop_pkg::DEFAULT_NAN;
                    end else if (is_inf(a) || is_inf(b)) begin
                        q_next.kind = frop_pkg::K_NANQ;
                        q_next.direct = is_inf(a) ? a : b;
                    end
                end else begin
                    if ((is_inf(a) && is_zero(b)) || (is_inf(b) && is_zero(a))) begin
                        q_next.kind = frop_pkg::K_NANQ;
                        q_next.direct = frop_pkg::DEFAULT_NAN;
                    end else if (is_inf(a) || is_inf(b)) begin
                        q_next.kind = frop_pkg::K_NANQ;
                        q_next.direct = {a[31] ^ b[31], 31'h7F80_0000};
                    end
                end
            end
            default: q_next.direct = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg <= q_next;
        end
    end
endmodule

/* hw/rtl/frop_arith.sv */
// Second stage: aligned add/subtract, 24x24 multiply, or integer magnitude,
// giving an unnormalised sign, exponent and mantissa. Depends on frop_pkg.
module frop_arith (
    input  logic          aclk,
    input  logic          en,
    input  frop_pkg::s1_t d,
    output frop_pkg::s2_t q_reg
);
    frop_pkg::s2_t q_next;

    always_comb begin
        logic        swap;
        logic [9:0]  eh, el, diff;
        logic [23:0] mh, ml;
        logic        sh, sl;
        logic [49:0] big, small_v, shifted;
        logic        sticky;
        logic [31:0] mag;
        logic [47:0] prod;
        swap = {d.ea, d.ma} < {d.eb, d.mb};
        eh = swap ? d.eb : d.ea;
        el = swap ? d.ea : d.eb;
        mh = swap ? d.mb : d.ma;
        ml = swap ? d.ma : d.mb;
        sh = swap ? d.sb : d.sa;
        sl = swap ? d.sa : d.sb;
        diff = eh - el;
        big = {1'b0, mh, 25'd0};
        small_v = {1'b0, ml, 25'd0};
        shifted = (diff > 10'd49) ? 50'd0 : (small_v >> diff);
        sticky = (diff > 10'd49) ? (ml != 24'd0)
                                 : ((small_v & ~({50{1'b1}} << diff)) != 50'd0);
        shifted[0] = shifted[0] | sticky;
        mag = d.ival[31] ? (~d.ival + 32'd1) : d.ival;
        prod = d.ma * d.mb;
        q_next = '0;
        q_next.last = d.last;
        q_next.kind = d.kind;
        q_next.direct = d.direct;
        case (d.kind)
            frop_pkg::K_SUM: begin
                // Value = mant * 2^(exp - 127 - 49).
                q_next.sign = sh;
                q_next.exp = $signed({2'b00, eh}) + 12'sd1;
                q_next.mant = (sh == sl) ? (big + shifted) : (big - shifted);
                q_next.zero = (q_next.mant == 50'd0);
                if (q_next.zero) begin
                    q_next.sign = sh & sl;
                end
            end
            frop_pkg::K_PROD: begin
                q_next.sign = d.sa ^ d.sb;
                q_next.mant = {2'b00, prod};
                q_next.exp = $signed({2'b00, d.ea}) + $signed({2'b00, d.eb}) - 12'sd124;
                q_next.zero = (q_next.mant == 50'd0);
            end
            frop_pkg::K_INT: begin
                // Bit 31 of the magnitude lands on bit 49, worth 2^31.
                q_next.sign = d.ival[31];
                q_next.mant = {mag, 18'd0};
                q_next.exp = 12'sd158;
                q_next.zero = (d.ival == 32'd0);
            end
            default: q_next.zero = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg <= q_next;
        end
    end
endmodule

/* hw/rtl/frop_norm.sv */
// Third stage: leading-one normalisation and subnormal denormalisation to a
// 27-bit mantissa with guard, round and sticky bits. Depends on frop_pkg.
module frop_norm (
    input  logic          aclk,
    input  logic          en,
    input  frop_pkg::s2_t d,
    output frop_pkg::s3_t q_reg
);
    frop_pkg::s3_t q_next;

    always_comb begin
        logic [5:0]  lz;
        logic [49:0] n;
        logic signed [11:0] e;
        logic [12:0] rsh;
        logic [49:0] dn;
        logic        st;
        lz = 6'd0;
        for (int i = 0; i < 50; i++) begin
            if (d.mant[i]) begin
                lz = 6'(49 - i);
            end
        end
        n = d.mant << lz;
        // Leading one at bit 49 means value = 1.x * 2^(e-127).
        e = d.exp - $signed({6'd0, lz});
        rsh = 13'd0;
        if (e < 12'sd1) begin
            rsh = 13'(12'sd1 - e);
            e = 12'sd0;
        end
        dn = (rsh > 13'd49) ? 50'd0 : (n >> rsh);
        st = (rsh > 13'd49) ? (n != 50'd0) : ((n & ~({50{1'b1}} << rsh)) != 50'd0);
        q_next.last = d.last;
        q_next.kind = d.kind;
        q_next.direct = d.direct;
        q_next.sign = d.sign;
        q_next.zero = d.zero;
        q_next.exp = e;
        q_next.mant = {dn[49:24], (dn[23:0] != 24'd0) | st};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg <= q_next;
        end
    end
endmodule

/* hw/rtl/float_reduction_operator_alu.sv */
// Float reduction operator ALU, top level: four register stages (decode,
// arithmetic, normalise, round/output). A word accepted into the decode
// register moves on through the arithmetic, normalise and round/output
// registers before it shows on m_valid. Throughput is one word per cycle,
// set by the fully pipelined stages; a stall freezes all stages together.
// Reset (aresetn low, synchronous) clears valid bits and sets operation to max.
module float_reduction_operator_alu (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_operand_a,
    input  logic [31:0] s_operand_b,
    input  logic        s_last_element,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_result_bits,
    output logic        m_result_last
);
    logic [3:0] operation_reg;
    logic [3:0] vld_reg;
    logic       adv;
    frop_pkg::s1_t s1;
    frop_pkg::s2_t s2;
    frop_pkg::s3_t s3;
    logic [31:0] res_next, res_reg;
    logic        last_reg;

    // The whole pipeline moves when the output word is free or being taken.
    assign adv = !vld_reg[3] || m_ready;
    assign s_ready = adv;

    frop_decode u_dec (.aclk, .en(adv), .operation(operation_reg), .a(s_operand_a),
                       .b(s_operand_b), .last(s_last_element), .q_reg(s1));
    frop_arith u_ar (.aclk, .en(adv), .d(s1), .q_reg(s2));
    frop_norm u_nm (.aclk, .en(adv), .d(s2), .q_reg(s3));

    // Round to nearest even, then pack; an overflow of the rounded exponent
    // becomes infinity.
    always_comb begin
        logic [24:0] r;
        logic        up;
        logic [8:0]  ex;
        up = s3.mant[2] && (s3.mant[1] || s3.mant[0] || s3.mant[3]);
        r = {1'b0, s3.mant[26:3]} + {24'd0, up};
        ex = {1'b0, s3.exp[7:0]};
        if (r[24]) begin
            r = r >> 1;
            ex = ex + 9'd1;
        end else if (s3.exp == 12'sd0 && r[23]) begin
            ex = 9'd1;
        end
        case (s3.kind) inside
            frop_pkg::K_SUM, frop_pkg::K_PROD, frop_pkg::K_INT: begin
                if (s3.zero) begin
                    res_next = {s3.sign, 31'd0};
                end else if (s3.exp > 12'sd254 || ex >= 9'd255) begin
                    res_next = {s3.sign, 8'hFF, 23'd0};
                end else begin
                    res_next = {s3.sign, ex[7:0], r[22:0]};
                end
            end
            default: res_next = s3.direct;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            operation_reg <= 4'd0;
            vld_reg <= 4'd0;
        end else begin
            if (cfg_we) begin
                operation_reg <= cfg_wdata;
            end
            if (adv) begin
                vld_reg <= {vld_reg[2:0], s_valid};
            end
        end
        if (adv) begin
            res_reg <= res_next;
            last_reg <= s3.last;
        end
    end

    assign m_valid = vld_reg[3];
    assign m_result_bits = res_reg;
    assign m_result_last = last_reg;
endmodule

/* test/tb_float_reduction_operator_alu.sv */
// Testbench for float_reduction_operator_alu: drives element pairs under every
// operation setting and checks each result word against a bit-exact predictor.
// Depends on frop_pkg and the RTL of the block; reads no files.
`timescale 1ns / 1ps

module tb_float_reduction_operator_alu;

    typedef struct {
        logic [31:0] a;
        logic [31:0] b;
        logic        last;
    } pair_t;

    typedef struct {
        logic [31:0] bits;
        logic        last;
    } combined_t;

    localparam int CYCLE_LIMIT = 400000;
    localparam int BATCHES     = 26;
    localparam int BATCH_ITEMS = 52;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [3:0]  cfg_wdata = 4'd0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_operand_a = 32'd0;
    logic [31:0] s_operand_b = 32'd0;
    logic        s_last_element = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_result_bits;
    logic        m_result_last;

    // The operation that the block holds, tracked alongside its register.
    logic [3:0]  current_op = frop_pkg::OP_MAX;

    pair_t       pending_pairs[$];
    combined_t   expected_words[$];
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          sender_hold = 1'b0;
    int          error_count = 0;
    int          cycle_count = 0;

    float_reduction_operator_alu dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operand_a    (s_operand_a),
        .s_operand_b    (s_operand_b),
        .s_last_element (s_last_element),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_bits  (m_result_bits),
        .m_result_last  (m_result_last)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor. All float arithmetic is done exactly on wide integers and
    // rounded once, to nearest even, so no simulator real type is trusted.
    // ------------------------------------------------------------------

    function automatic bit is_nan(logic [31:0] x);
        return x[30:23] == 8'hFF && x[22:0] != 23'd0;
    endfunction

    function automatic bit is_inf(logic [31:0] x);
        return x[30:23] == 8'hFF && x[22:0] == 23'd0;
    endfunction

    // Splits a finite float into sign, integer significand and the weight of
    // its least significant bit, so that the value is sig * 2^lsb_exp.
    function automatic void split_float(input logic [31:0] x, output bit sgn,
                                        output logic [23:0] sig, output int lsb_exp);
        sgn = x[31];
        if (x[30:23] == 8'd0) begin
            sig = {1'b0, x[22:0]};
            lsb_exp = -149;
        end else begin
            sig = {1'b1, x[22:0]};
            lsb_exp = int'(x[30:23]) - 150;
        end
    endfunction

    // Rounds sgn * mag * 2^e to single precision, subnormals and overflow to
    // infinity included. A zero magnitude gives a zero of the given sign.
    function automatic logic [31:0] round_to_single(bit sgn, logic [319:0] mag, int e);
        int          msb;
        int          keep_exp;
        int          sh;
        int          biased;
        logic [319:0] q;
        bit          guard;
        bit          sticky;
        msb = -1;
        for (int i = 319; i >= 0; i--) begin
            if (mag[i] && msb < 0) msb = i;
        end
        if (msb < 0) return {sgn, 31'd0};
        keep_exp = (msb + e - 23 > -149) ? msb + e - 23 : -149;
        sh = keep_exp - e;
        if (sh <= 0) begin
            q = mag << (-sh);
        end else begin
            q = mag >> sh;
            guard = mag[sh - 1];
            sticky = |(mag & ~({320{1'b1}} << (sh - 1)));
            if (guard && (sticky || q[0])) q = q + 1;
        end
        if (q[24]) begin
            q = q >> 1;
            keep_exp++;
        end
        if (!q[23]) return {sgn, 8'd0, q[22:0]};
        biased = keep_exp + 150;
        if (biased >= 255) return {sgn, 8'hFF, 23'd0};
        return {sgn, biased[7:0], q[22:0]};
    endfunction

    // NaN results of the arithmetic operations propagate the first NaN
    // operand, quietened, or else give the default NaN.
    function automatic logic [31:0] nan_result(logic [31:0] a, logic [31:0] b);
        if (is_nan(a)) return a | 32'h0040_0000;
        if (is_nan(b)) return b | 32'h0040_0000;
        return frop_pkg::DEFAULT_NAN;
    endfunction

    function automatic logic [31:0] float_sum(logic [31:0] a, logic [31:0] b);
        bit           sa, sb;
        logic [23:0]  ma, mb;
        int           ea, eb, emin;
        logic [319:0] wa, wb;
        if (is_nan(a) || is_nan(b)) return nan_result(a, b);
        if (is_inf(a) && is_inf(b) && a[31] != b[31]) return frop_pkg::DEFAULT_NAN;
        if (is_inf(a)) return a;
        if (is_inf(b)) return b;
        split_float(a, sa, ma, ea);
        split_float(b, sb, mb, eb);
        emin = (ea < eb) ? ea : eb;
        wa = 320'(ma) << (ea - emin);
        wb = 320'(mb) << (eb - emin);
        if (sa == sb) return round_to_single(sa, wa + wb, emin);
        // Exact cancellation gives +0 under round to nearest.
        if (wa == wb) return 32'd0;
        if (wa > wb) return round_to_single(sa, wa - wb, emin);
        return round_to_single(sb, wb - wa, emin);
    endfunction

    function automatic logic [31:0] float_product(logic [31:0] a, logic [31:0] b);
        bit          sa, sb;
        logic [23:0] ma, mb;
        int          ea, eb;
        if (is_nan(a) || is_nan(b)) return nan_result(a, b);
        if (is_inf(a) || is_inf(b)) begin
            if (a[30:0] == 31'd0 || b[30:0] == 31'd0) return frop_pkg::DEFAULT_NAN;
            return {a[31] ^ b[31], 8'hFF, 23'd0};
        end
        split_float(a, sa, ma, ea);
        split_float(b, sb, mb, eb);
        return round_to_single(sa ^ sb, 320'(ma) * 320'(mb), ea + eb);
    endfunction

    // Total order for non-NaN values; both zeros map to the same key.
    function automatic longint order_key(logic [31:0] x);
        return x[31] ? -longint'(x[30:0]) : longint'(x[30:0]);
    endfunction

    function automatic bit float_greater(logic [31:0] a, logic [31:0] b);
        if (is_nan(a) || is_nan(b)) return 1'b0;
        return order_key(a) > order_key(b);
    endfunction

    // Truncation toward zero with saturation; NaN becomes zero.
    function automatic logic [31:0] truncate_int(logic [31:0] x);
        int unsigned ex;
        logic [31:0] sig;
        logic [31:0] mag;
        ex = x[30:23];
        if (is_nan(x) || ex < 127) return 32'd0;
        if (ex >= 158) return x[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        sig = {9'd0, 1'b1, x[22:0]};
        mag = (ex - 127 >= 23) ? sig << (ex - 150) : sig >> (150 - ex);
        return x[31] ? -mag : mag;
    endfunction

    function automatic logic [31:0] int_to_single(logic [31:0] v);
        logic [32:0] mag;
        mag = v[31] ? (33'h1_0000_0000 - {1'b0, v}) : {1'b0, v};
        return round_to_single(v[31], 320'(mag), 0);
    endfunction

    function automatic logic [31:0] combine_pair(logic [3:0] op, logic [31:0] a,
                                                 logic [31:0] b);
        bit nz_a;
        bit nz_b;
        nz_a = a[30:0] != 31'd0;
        nz_b = b[30:0] != 31'd0;
        case (op)
            frop_pkg::OP_MAX:  return float_greater(a, b) ? a : b;
            frop_pkg::OP_MIN:  return float_greater(b, a) ? a : b;
            frop_pkg::OP_SUM:  return float_sum(a, b);
            frop_pkg::OP_PROD: return float_product(a, b);
            frop_pkg::OP_LAND: return (nz_a && nz_b) ? frop_pkg::ONE_BITS : 32'd0;
            frop_pkg::OP_LOR:  return (nz_a || nz_b) ? frop_pkg::ONE_BITS : 32'd0;
            frop_pkg::OP_LXOR: return (nz_a != nz_b) ? frop_pkg::ONE_BITS : 32'd0;
            frop_pkg::OP_BAND: return int_to_single(truncate_int(a) & truncate_int(b));
            frop_pkg::OP_BOR:  return int_to_single(truncate_int(a) | truncate_int(b));
            default: return 32'd0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver: presents queued pairs, holding each word until it is taken.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        pair_t     next_pair;
        combined_t word;
        bit        taken;
        taken = s_valid && s_ready;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (taken) begin
                word.bits = combine_pair(current_op, s_operand_a, s_operand_b);
                word.last = s_last_element;
                expected_words.push_back(word);
            end
            if (s_valid && !taken) begin
                // Word still waiting: valid and payload stay as they are.
            end else if (pending_pairs.size() > 0 && !sender_hold &&
                         $urandom_range(0, 99) >= send_idle_pct) begin
                next_pair = pending_pairs.pop_front();
                s_valid <= 1'b1;
                s_operand_a <= next_pair.a;
                s_operand_b <= next_pair.b;
                s_last_element <= next_pair.last;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each accepted result word against the oldest expected
    // one, and applies back-pressure at random.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        combined_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected result word bits=%h last=%b",
                             $time, m_result_bits, m_result_last);
                    error_count++;
                end else begin
                    want = expected_words.pop_front();
                    if (m_result_bits !== want.bits) begin
                        $display("%0t: result_bits mismatch, expected %h, actual %h",
                                 $time, want.bits, m_result_bits);
                        error_count++;
                    end
                    if (m_result_last !== want.last) begin
                        $display("%0t: result_last mismatch, expected %b, actual %b",
                                 $time, want.last, m_result_last);
                        error_count++;
                    end
                end
            end
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus generation.
    // ------------------------------------------------------------------

    function automatic logic [31:0] random_operand();
        logic [31:0] corner[15] = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000,
                                    32'hFF80_0000, 32'h7FC0_0000, 32'h7F80_0001,
                                    32'hFFFF_FFFF, 32'h0000_0001, 32'h807F_FFFF,
                                    32'h3F80_0000, 32'h4F00_0000, 32'hCF00_0000,
                                    32'h4EFF_FFFF, 32'hCF00_0001, 32'h7F7F_FFFF};
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return corner[$urandom_range(0, 14)];
            2: return {1'($urandom), 8'd0, 23'($urandom)};
            3: return int_to_single($urandom);
            4: return int_to_single(32'($signed(16'($urandom))));
            default: return {1'($urandom), 8'($urandom_range(100, 160)), 23'($urandom)};
        endcase
    endfunction

    function automatic pair_t random_pair();
        pair_t p;
        p.a = random_operand();
        case ($urandom_range(0, 9))
            // Near-cancellation and equal operands stress sum and compare.
            0: p.b = p.a ^ 32'h8000_0000 ^ 32'($urandom_range(0, 7));
            1: p.b = p.a;
            2: p.b = {p.a[31:23] + 9'($urandom_range(0, 30)), 23'($urandom)};
            default: p.b = random_operand();
        endcase
        p.last = ($urandom_range(0, 7) == 0);
        return p;
    endfunction

    task automatic wait_idle();
        // Look just after each edge, once the driver's updates have landed,
        // so that a word launched in the same cycle is not missed.
        #1;
        while (pending_pairs.size() > 0 || s_valid || expected_words.size() > 0) begin
            @(posedge aclk);
            #1;
        end
        // Let the four pipeline stages drain before anything changes.
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_operation(logic [3:0] op);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_wdata <= op;
        @(posedge aclk);
        cfg_we <= 1'b0;
        current_op = op;
    endtask

    task automatic set_idling(int mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
            default: begin send_idle_pct = 12; recv_stall_pct = 12; end
        endcase
    endtask

    initial begin
        // Directed pairs: signed zeros, infinities, NaNs of both kinds,
        // subnormals, overflow, ties for rounding and the int32 saturation edges.
        logic [31:0] directed[20][2] = '{
            '{32'h0000_0000, 32'h8000_0000}, '{32'h8000_0000, 32'h0000_0000},
            '{32'h7F80_0000, 32'hFF80_0000}, '{32'h7F80_0000, 32'h0000_0000},
            '{32'h7FA0_0000, 32'h3F80_0000}, '{32'h3F80_0000, 32'hFFA0_0001},
            '{32'h7FFF_FFFF, 32'h7FC0_0000}, '{32'h0000_0001, 32'h0000_0001},
            '{32'h807F_FFFF, 32'h007F_FFFF}, '{32'h7F7F_FFFF, 32'h7F7F_FFFF},
            '{32'h0080_0000, 32'h3F00_0000}, '{32'h4F00_0000, 32'hCF00_0000},
            '{32'hCF00_0001, 32'h4EFF_FFFF}, '{32'h3F80_0000, 32'hBF80_0000},
            '{32'hFFFF_FFFF, 32'h0000_0000}, '{32'h3FC0_0000, 32'hC020_0000},
            '{32'h8000_0000, 32'h8000_0000}, '{32'h3380_0000, 32'h3F80_0000},
            '{32'h3F80_0001, 32'h3F7F_FFFF}, '{32'h0000_0000, 32'h7F80_0001}};
        logic [3:0] op_order[10] = '{frop_pkg::OP_MAX, frop_pkg::OP_MIN,
                                     frop_pkg::OP_SUM, frop_pkg::OP_PROD,
                                     frop_pkg::OP_LAND, frop_pkg::OP_BAND,
                                     frop_pkg::OP_LOR, frop_pkg::OP_BOR,
                                     frop_pkg::OP_LXOR, 4'hF};
        pair_t p;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, run once under each operation including an unused code.
        for (int k = 0; k < 10; k++) begin
            write_operation(op_order[k]);
            set_idling(k % 4);
            for (int i = 0; i < 20; i++) begin
                p.a = directed[i][0];
                p.b = directed[i][1];
                p.last = i[0];
                pending_pairs.push_back(p);
            end
        end

        // Random part: operations and idling modes rotate batch by batch, so
        // every operation meets at least two modes over the run.
        for (int k = 0; k < BATCHES; k++) begin
            write_operation(op_order[k % 10]);
            set_idling(k % 4);
            for (int i = 0; i < BATCH_ITEMS; i++)
                pending_pairs.push_back(random_pair());
            if (k == 5) begin
                // Midway through a batch the sender holds off until the
                // pipeline has returned every outstanding result word.
                while (pending_pairs.size() > BATCH_ITEMS / 2) @(posedge aclk);
                sender_hold = 1'b1;
                #1;
                while (s_valid || expected_words.size() > 0) begin
                    @(posedge aclk);
                    #1;
                end
                sender_hold = 1'b0;
            end
        end

        wait_idle();
        repeat (20) @(posedge aclk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
